FILE: sv/mesh_duplicate_filter_forwarder_unit_assert.svh
// Assertion macros used by the checker file of the duplicate filter.
`ifndef MESH_DUPLICATE_FILTER_FORWARDER_UNIT_ASSERT_SVH
`define MESH_DUPLICATE_FILTER_FORWARDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDFF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdff assertion failed");

// Next-cycle implication, checked out of reset.
`define MDFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdff assertion failed");

`endif

FILE: sv/mdff_pkg.sv
// Package: types and constants of the mesh duplicate filter.
`default_nettype none
package mdff_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 32;

  localparam int unsigned CALL_W = 56;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned KEY_W  = CALL_W + ID_W;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RSSI = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN  = 8'd1;

  localparam logic signed [8:0] RSSI_OFFSET  = 9'sd157;
  localparam logic signed [8:0] RSSI_RESET   = -9'sd105;
  localparam logic [7:0]        LENGTH_RESET = 8'd22;
  localparam int unsigned       CHAT_BIT     = 3;
  localparam logic [7:0]        LAST_HOP     = 8'd1;

  typedef enum logic [2:0] {
    VERDICT_SHORT = 3'd0,
    VERDICT_DUP   = 3'd1,
    VERDICT_SPENT = 3'd2,
    VERDICT_WEAK  = 3'd3,
    VERDICT_FWD   = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } scan_state_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic idle;
    logic finish;
    logic hit;
    logic too_short;
  } mdff_status_t;

endpackage
`default_nettype wire

FILE: sv/mdff_cache_mem.sv
// Single-port-write, single-port-read cache RAM with registered read data.
`default_nettype none
module mdff_cache_mem #(
  parameter int unsigned ENTRIES = mdff_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned WIDTH   = mdff_pkg::KEY_W,
  parameter int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);
  import mdff_pkg::*;

  logic [WIDTH-1:0] ram_r [ENTRIES];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ram_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/mdff_scan_ctrl.sv
// Lookup sequencer: scans the filled part of the cache ring, then stores the key of a new, long enough frame.
`default_nettype none
module mdff_scan_ctrl #(
  parameter int unsigned ENTRIES = mdff_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       start_short,
  input  logic [mdff_pkg::CALL_W-1:0] key_call,
  input  logic [mdff_pkg::ID_W-1:0]   key_id,
  input  logic                       out_free,
  output mdff_pkg::mdff_status_t     status
);
  import mdff_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [FW-1:0] FULL      = FW'(ENTRIES);

  scan_state_t   state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          hit_r, hit_nxt;
  logic          short_r, short_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_en, wr_en;
  logic [KEY_W-1:0] rd_data;
  logic [KEY_W-1:0] key;

  assign key = {key_call, key_id};

  mdff_cache_mem #(
    .ENTRIES (ENTRIES),
    .WIDTH   (KEY_W),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      addr_r    <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      hit_r     <= 1'b0;
      short_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      hit_r     <= hit_nxt;
      short_r   <= short_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    hit_nxt     = hit_r;
    short_nxt   = short_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_pend_nxt = (state_r == ST_SCAN);
    // compare the entry read in the previous cycle
    if (rd_pend_r && (rd_data == key)) begin
      hit_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          short_nxt = start_short;
          hit_nxt   = 1'b0;
          addr_nxt  = '0;
          state_nxt = (start_short || (fill_r == '0)) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (FW'(addr_r) == (fill_r - FW'(1))) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (!short_r && !hit_r) begin
            wr_en  = 1'b1;
            wp_nxt = (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
            if (fill_r != FULL) begin
              fill_nxt = fill_r + FW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fields in order: idle, finish, hit, too_short
  assign status = {(state_r == ST_IDLE), (state_r == ST_FINISH), hit_r, short_r};

endmodule
`default_nettype wire

FILE: sv/mesh_duplicate_filter_forwarder_unit.sv
// Top level of the mesh duplicate filter and flood forwarder.
`default_nettype none
// Usage:
//   Input channel (in_valid / in_stall): one beat is one received frame header.
//   A beat is taken when in_valid is high and in_stall is low. in_stall is high
//   while a frame is being looked up, so one frame is in work at a time.
//   Result channel (out_valid / out_stall): exactly one result beat per frame,
//   held steady in the output register while out_stall is high.
//   Config channel (cfg_valid / cfg_ready): index 0 is the forwarding signal
//   threshold in dBm, index 1 the minimum frame length; cfg_ready is always high
//   and other indexes are ignored. Write only while the block is idle.
// Timing:
//   A short frame, or any frame while the cache is empty, goes straight to the final
//   step, which loads the output register. Otherwise the lookup reads one entry per
//   cycle over the F entries filled so far (F at most CACHE_ENTRIES), passes a drain
//   step for the last read and loads the result in the final step; the next beat is
//   taken once the block is back in idle. When the result register is still full
//   and stalled, the block waits in its final step until the receiver takes the
//   earlier beat.
// Reset:
//   rst_n (synchronous, active low) empties the cache by clearing its fill count
//   and write pointer; no clearing pass runs. Thresholds return to -105 dBm / 22.
module mesh_duplicate_filter_forwarder_unit #(
  parameter int unsigned CACHE_ENTRIES = mdff_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input frames
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [55:0]                     in_source_call,
  input  logic [15:0]                     in_message_id,
  input  logic [7:0]                      in_hop_limit,
  input  logic [7:0]                      in_frame_flags,
  input  logic [7:0]                      in_frame_length,
  input  logic [7:0]                      in_rssi_raw,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_verdict,
  output logic                            out_is_chat,
  output logic [7:0]                      out_hop_limit_out,
  output logic signed [8:0]               out_signal_dbm,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdff_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mdff_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mdff_pkg::*;

  // configuration registers
  logic signed [8:0] min_rssi_r;
  logic [7:0]        min_len_r;

  // held frame fields
  logic [CALL_W-1:0] call_r;
  logic [ID_W-1:0]   id_r;
  logic [7:0]        hops_r;
  logic [7:0]        flags_r;
  logic [7:0]        rssi_raw_r;

  // result register
  logic              out_valid_r, out_valid_nxt;
  verdict_t          verdict_r, verdict_nxt;
  logic              chat_r, chat_nxt;
  logic [7:0]        hop_out_r, hop_out_nxt;
  logic signed [8:0] dbm_r;

  mdff_status_t      status;
  logic              in_accept;
  logic              in_short;
  logic              out_free;
  logic              load_out;
  logic signed [8:0] dbm;

  assign cfg_ready = 1'b1;
  assign in_stall  = !status.idle;
  assign in_accept = in_valid && !in_stall;
  assign in_short  = (in_frame_length < min_len_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = status.finish && out_free;

  // Config writes: keep only the bits each register holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rssi_r <= RSSI_RESET;
      min_len_r  <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_RSSI: min_rssi_r <= $signed(cfg_data[8:0]);
        CFG_MIN_LEN:  min_len_r  <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // Capture the frame header on acceptance; it stays put for the whole lookup.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      call_r     <= in_source_call;
      id_r       <= in_message_id;
      hops_r     <= in_hop_limit;
      flags_r    <= in_frame_flags;
      rssi_raw_r <= in_rssi_raw;
    end
  end

  mdff_scan_ctrl #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_accept),
    .start_short (in_short),
    .key_call    (call_r),
    .key_id      (id_r),
    .out_free    (out_free),
    .status      (status)
  );

  // Signal strength in dBm: raw reading minus the fixed offset.
  assign dbm = $signed({1'b0, rssi_raw_r}) - RSSI_OFFSET;

  // Verdict: short frame, then duplicate, then hop and signal checks.
  always_comb begin
    verdict_nxt = VERDICT_FWD;
    chat_nxt    = 1'b0;
    hop_out_nxt = '0;
    if (status.too_short) begin
      verdict_nxt = VERDICT_SHORT;
    end else if (status.hit) begin
      verdict_nxt = VERDICT_DUP;
    end else begin
      chat_nxt = flags_r[CHAT_BIT];
      if (hops_r <= LAST_HOP) begin
        verdict_nxt = VERDICT_SPENT;
      end else if (dbm < min_rssi_r) begin
        verdict_nxt = VERDICT_WEAK;
      end else begin
        verdict_nxt = VERDICT_FWD;
        hop_out_nxt = hops_r - 8'd1;
      end
    end
  end

  // Hold the result beat until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict_r <= verdict_nxt;
      chat_r    <= chat_nxt;
      hop_out_r <= hop_out_nxt;
      dbm_r     <= dbm;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_is_chat       = chat_r;
  assign out_hop_limit_out = hop_out_r;
  assign out_signal_dbm    = dbm_r;

endmodule
`default_nettype wire

FILE: sv/mdff_checker.sv
// Port-level checker for the duplicate filter, bound to the top level.
`default_nettype none
`include "mesh_duplicate_filter_forwarder_unit_assert.svh"
module mdff_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_verdict,
  input logic        out_is_chat,
  input logic [7:0]  out_hop_limit_out,
  input logic [8:0]  out_signal_dbm
);
  import mdff_pkg::*;

  // A stalled result beat holds.
  `MDFF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_verdict) && $stable(out_signal_dbm))

  // One frame at a time: taking a beat closes the input.
  `MDFF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // Only a forwarded frame carries a hop count.
  `MDFF_ASSERT_NOW(a_hop_only_fwd, out_valid && (out_verdict != VERDICT_FWD), out_hop_limit_out == 8'd0)

  // A forwarded frame had at least two hops left.
  `MDFF_ASSERT_NOW(a_fwd_hops, out_valid && (out_verdict == VERDICT_FWD), out_hop_limit_out != 8'd0)

  // Short and duplicate frames never report chat.
  `MDFF_ASSERT_NOW(a_chat_new_only, out_valid && ((out_verdict == VERDICT_SHORT) || (out_verdict == VERDICT_DUP)), !out_is_chat)

endmodule

bind mesh_duplicate_filter_forwarder_unit mdff_checker u_mdff_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_verdict       (out_verdict),
  .out_is_chat       (out_is_chat),
  .out_hop_limit_out (out_hop_limit_out),
  .out_signal_dbm    (out_signal_dbm)
);
`default_nettype wire

FILE: verif/mesh_duplicate_filter_forwarder_unit_tb.sv
// Self-checking testbench for the mesh duplicate filter and flood forwarder.
`timescale 1ns / 1ps
`default_nettype none
module mesh_duplicate_filter_forwarder_unit_tb;
  import mdff_pkg::*;

  localparam int unsigned RING_DEPTH = CACHE_ENTRIES_DEF;
  localparam int unsigned HISTORY_DEPTH = 64;     // deeper than the ring, so evicted pairs return
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned BEATS_PER_PHASE = 215;
  localparam int unsigned QUIET_LIMIT = 4000;     // cycles without any beat on any channel
  localparam int unsigned DRAIN_CYCLES = 2 * (RING_DEPTH + 3);
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 8'd2;

  // Idle modes, one per phase.
  localparam int unsigned MODE_SENDER = 1;
  localparam int unsigned MODE_RECEIVER = 2;
  localparam int unsigned MODE_BOTH = 3;

  typedef struct packed {
    logic [55:0] source_call;
    logic [15:0] message_id;
    logic [7:0]  hop_limit;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_length;
    logic [7:0]  rssi_raw;
  } header_t;

  typedef struct packed {
    verdict_t          verdict;
    logic              is_chat;
    logic [7:0]        hop_limit_out;
    logic signed [8:0] signal_dbm;
  } decision_t;

  typedef struct packed {
    header_t   hdr;
    logic      typed;      // 1: use the hand-written decision below
    decision_t want;
  } directed_row_t;

  localparam decision_t NOT_TYPED = '{VERDICT_SHORT, 1'b0, 8'd0, 9'sd0};
  localparam int unsigned DIRECTED_ROWS = 15;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [55:0] in_source_call;
  logic [15:0] in_message_id;
  logic [7:0] in_hop_limit;
  logic [7:0] in_frame_flags;
  logic [7:0] in_frame_length;
  logic [7:0] in_rssi_raw;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_verdict;
  logic out_is_chat;
  logic [7:0] out_hop_limit_out;
  logic signed [8:0] out_signal_dbm;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mesh_duplicate_filter_forwarder_unit #(
    .CACHE_ENTRIES(CACHE_ENTRIES_DEF)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_call   (in_source_call),
    .in_message_id    (in_message_id),
    .in_hop_limit     (in_hop_limit),
    .in_frame_flags   (in_frame_flags),
    .in_frame_length  (in_frame_length),
    .in_rssi_raw      (in_rssi_raw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_is_chat      (out_is_chat),
    .out_hop_limit_out(out_hop_limit_out),
    .out_signal_dbm   (out_signal_dbm),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Mirror of the block's duplicate ring and thresholds.
  logic              seen_valid [RING_DEPTH];
  logic [55:0]       seen_call [RING_DEPTH];
  logic [15:0]       seen_id [RING_DEPTH];
  int unsigned       ring_ptr;
  int                rssi_floor;
  int unsigned       length_floor;

  // Decisions still owed by the block, oldest first.
  decision_t         owed_decisions [$];

  // Recently sent pairs, reused to provoke duplicates and re-entries after eviction.
  logic [55:0]       sent_call [HISTORY_DEPTH];
  logic [15:0]       sent_id [HISTORY_DEPTH];
  int unsigned       sent_fill;
  int unsigned       sent_ptr;

  int unsigned       sender_idle_pct;
  int unsigned       receiver_stall_pct;
  int unsigned       error_count;
  int unsigned       quiet_cycles;

  directed_row_t     directed_rows [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the block's answer to one header and advance the mirrored ring.
  function automatic decision_t judge_header(header_t h);
    decision_t d;
    int dbm;
    bit hit;
    d = NOT_TYPED;
    dbm = int'(h.rssi_raw) - int'(RSSI_OFFSET);
    d.signal_dbm = dbm[8:0];
    if (h.frame_length < length_floor) begin
      d.verdict = VERDICT_SHORT;
    end else begin
      hit = 1'b0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        if (seen_valid[k] && seen_call[k] == h.source_call && seen_id[k] == h.message_id) begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        d.verdict = VERDICT_DUP;
      end else begin
        seen_valid[ring_ptr] = 1'b1;
        seen_call[ring_ptr] = h.source_call;
        seen_id[ring_ptr] = h.message_id;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        d.is_chat = h.frame_flags[CHAT_BIT];
        if (h.hop_limit <= LAST_HOP) begin
          d.verdict = VERDICT_SPENT;
        end else if (dbm < rssi_floor) begin
          d.verdict = VERDICT_WEAK;
        end else begin
          d.verdict = VERDICT_FWD;
          d.hop_limit_out = h.hop_limit - 8'd1;
        end
      end
    end
    return d;
  endfunction

  // Build one random header: mostly long enough, with a good share of repeated pairs.
  function automatic header_t next_random_header();
    header_t h;
    logic [63:0] wide;
    int unsigned pick;
    int unsigned slot;
    pick = $urandom_range(99);
    wide = {$urandom, $urandom};
    h.source_call = wide[55:0];
    h.message_id = 16'($urandom_range(65535));
    if (sent_fill > 0 && pick < 45) begin
      slot = $urandom_range(sent_fill - 1);
      h.source_call = sent_call[slot];
      // a few reuse the sender only, so the id alone decides
      if (pick < 35) begin
        h.message_id = sent_id[slot];
      end
    end
    if (pick >= 35) begin
      sent_call[sent_ptr] = h.source_call;
      sent_id[sent_ptr] = h.message_id;
      sent_ptr = (sent_ptr + 1) % HISTORY_DEPTH;
      if (sent_fill < HISTORY_DEPTH) sent_fill++;
    end
    h.hop_limit = ($urandom_range(99) < 30) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    h.frame_flags = 8'($urandom_range(255));
    h.rssi_raw = 8'($urandom_range(255));
    if ($urandom_range(99) < 80) begin
      h.frame_length = 8'($urandom_range(255, length_floor));
    end else begin
      h.frame_length = 8'($urandom_range(255));
    end
    return h;
  endfunction

  task automatic flag_error(string what);
    if (error_count < REPORT_LIMIT) $display("ERROR: %s", what);
    error_count++;
  endtask

  // Offer one header; return at the edge that takes the beat, valid still high.
  task automatic send_header(header_t h, logic typed, decision_t want);
    decision_t d;
    // random gap before the beat
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_call <= h.source_call;
    in_message_id <= h.message_id;
    in_hop_limit <= h.hop_limit;
    in_frame_flags <= h.frame_flags;
    in_frame_length <= h.frame_length;
    in_rssi_raw <= h.rssi_raw;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // the mirror judges every beat, even where the answer is typed in
    d = judge_header(h);
    owed_decisions.push_back(typed ? want : d);
  endtask

  // Hold one register write until taken; the caller drops cfg_valid after the batch.
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_MIN_RSSI) begin
      rssi_floor = int'($signed(value));
    end else if (idx == CFG_MIN_LEN) begin
      length_floor = value[7:0];
    end
  endtask

  // Result side: random stall, check every beat against the oldest owed decision.
  initial begin : result_sink
    decision_t exp_d;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_decisions.size() == 0) begin
          flag_error($sformatf("result beat with nothing owed: verdict %0d", out_verdict));
        end else begin
          exp_d = owed_decisions.pop_front();
          if (out_verdict !== exp_d.verdict || out_is_chat !== exp_d.is_chat ||
              out_hop_limit_out !== exp_d.hop_limit_out ||
              out_signal_dbm !== exp_d.signal_dbm) begin
            flag_error($sformatf(
              "expected verdict %0d chat %0b hops %0d dbm %0d, got %0d %0b %0d %0d",
              exp_d.verdict, exp_d.is_chat, exp_d.hop_limit_out, exp_d.signal_dbm,
              out_verdict, out_is_chat, out_hop_limit_out, out_signal_dbm));
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int signed rssi_set;
    int unsigned length_set;
    int unsigned mode;

    // Every block input known from time zero.
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_source_call <= '0;
    in_message_id <= '0;
    in_hop_limit <= '0;
    in_frame_flags <= '0;
    in_frame_length <= '0;
    in_rssi_raw <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    error_count = 0;
    quiet_cycles = 0;
    sent_fill = 0;
    sent_ptr = 0;
    ring_ptr = 0;
    rssi_floor = int'(RSSI_RESET);
    length_floor = LENGTH_RESET;
    for (int k = 0; k < RING_DEPTH; k++) begin
      seen_valid[k] = 1'b0;
      seen_call[k] = '0;
      seen_id[k] = '0;
    end

    // Directed rows, run at reset thresholds (-105 dBm, 22 bytes).
    directed_rows = '{
      // shortest frame, weakest signal, all flags set
      '{'{56'h0, 16'h0000, 8'd0, 8'hFF, 8'd0, 8'd0}, 1'b1,
        '{VERDICT_SHORT, 1'b0, 8'd0, -9'sd157}},
      // one byte short of the floor, strongest signal
      '{'{56'hFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'd255, 8'hFF, 8'd21, 8'd255}, 1'b1,
        '{VERDICT_SHORT, 1'b0, 8'd0, 9'sd98}},
      // all ones, first sight: forwarded with hop limit one less
      '{'{56'hFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'd255, 8'hFF, 8'd255, 8'd255}, 1'b1,
        '{VERDICT_FWD, 1'b1, 8'd254, 9'sd98}},
      // the same pair again is a duplicate
      '{'{56'hFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'd255, 8'hFF, 8'd255, 8'd255}, 1'b1,
        '{VERDICT_DUP, 1'b0, 8'd0, 9'sd98}},
      // last hop, chat flag only, signal right at the threshold
      '{'{56'h0, 16'h0000, 8'd1, 8'h08, 8'd22, 8'd52}, 1'b1,
        '{VERDICT_SPENT, 1'b1, 8'd0, -9'sd105}},
      // hop limit zero, every flag but chat
      '{'{56'h0, 16'h0001, 8'd0, 8'hF7, 8'd22, 8'd200}, 1'b1,
        '{VERDICT_SPENT, 1'b0, 8'd0, 9'sd43}},
      // one dBm under the threshold
      '{'{56'h1, 16'h0000, 8'd2, 8'h00, 8'd100, 8'd51}, 1'b1,
        '{VERDICT_WEAK, 1'b0, 8'd0, -9'sd106}},
      // a stored pair that is too short is rejected on length first
      '{'{56'h1, 16'h0000, 8'd2, 8'h08, 8'd21, 8'd100}, 1'b0, NOT_TYPED},
      '{'{56'h1, 16'h0000, 8'd9, 8'h08, 8'd30, 8'd100}, 1'b0, NOT_TYPED},
      '{'{56'h2, 16'h0000, 8'd2, 8'h08, 8'd22, 8'd52}, 1'b0, NOT_TYPED},
      // top call bit alone, then top id bit alone, tell pairs apart
      '{'{56'h80_0000_0000_0000, 16'h0000, 8'd3, 8'h00, 8'd40, 8'd157}, 1'b0, NOT_TYPED},
      '{'{56'h0, 16'h8000, 8'd3, 8'h00, 8'd40, 8'd157}, 1'b0, NOT_TYPED},
      '{'{56'h0, 16'h0000, 8'd5, 8'h08, 8'd60, 8'd157}, 1'b0, NOT_TYPED},
      '{'{56'h55_5555_5555_5555, 16'h5555, 8'h80, 8'h55, 8'hAA, 8'hAA}, 1'b0, NOT_TYPED},
      '{'{56'hAA_AAAA_AAAA_AAAA, 16'hAAAA, 8'h7F, 8'hAA, 8'h55, 8'h55}, 1'b0, NOT_TYPED}
    };

    // Hold reset, then release it for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_header(directed_rows[r].hdr, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases: new thresholds and a new idle mode each time, written while idle.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      in_valid <= 1'b0;
      while (owed_decisions.size() != 0) @(posedge clk);

      case (p)
        0: begin rssi_set = -157; length_set = 0;   end
        1: begin rssi_set = 98;   length_set = 255; end
        2: begin rssi_set = int'(RSSI_RESET); length_set = LENGTH_RESET; end
        4: begin rssi_set = 0;    length_set = LENGTH_RESET; end
        default: begin
          rssi_set = int'($urandom_range(255)) - 157;
          length_set = $urandom_range(40);
        end
      endcase

      // the unmapped index and bit 8 of the length write must both be ignored
      write_register(CFG_UNMAPPED_LO + 8'($urandom_range(253)), 9'($urandom_range(511)));
      write_register(CFG_MIN_RSSI, 9'(rssi_set));
      write_register(CFG_MIN_LEN, {1'($urandom_range(1)), 8'(length_set)});
      cfg_valid <= 1'b0;

      mode = p % 4;
      sender_idle_pct = (mode == MODE_SENDER) ? 70 : (mode == MODE_BOTH) ? 27 : 0;
      receiver_stall_pct = (mode == MODE_RECEIVER) ? 70 : (mode == MODE_BOTH) ? 27 : 0;

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        send_header(next_random_header(), 1'b0, NOT_TYPED);
      end
    end

    // Drain, then give the block time to show any stray beat.
    in_valid <= 1'b0;
    while (owed_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && owed_decisions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
